@@ hdl/stab_pkg.sv @@
// Package for the session table: status and operation codes, record type, widths.
// No dependencies.
package stab_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;

    localparam logic [1:0] FUNC_CREATE  = 2'd0;
    localparam logic [1:0] FUNC_ACCEPT  = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;
    localparam logic [1:0] FUNC_GET     = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_MISMATCH  = 2'd3;

    typedef struct packed {
        logic        closed;
        logic [63:0] id;
        logic [63:0] epoch;
        logic [63:0] boot;
        logic [63:0] nonce;
        logic [63:0] last_seq;
        logic [31:0] active;
    } slot_rec_t;

    // Request that travels down the row of cells, one cell per cycle.
    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] id;
        logic [63:0] epoch;
        logic [63:0] boot;
        logic [63:0] seq;
        logic [63:0] nonce;
        logic [63:0] new_id;
        logic        alloc;     // create may claim the first unused slot
        logic        done;      // some earlier cell has handled the item
        logic [1:0]  status;
        logic        emit;      // record below is reported
        slot_rec_t   rec;
        logic [5:0]  open_cnt;  // open slots counted so far after update
    } req_t;

endpackage

@@ hdl/session_table_with_replay_check.sv @@
// Top level of the session table: row of slot cells and result register.
// Depends on stab_pkg and stab_cell.
//
//   channel  | ports                         | direction
//   s_       | s_valid/s_ready + fields      | item in
//   m_       | m_valid/m_ready + fields      | result out
//   cfg      | cfg_we/cfg_data               | session_limit write
//
// An item walks the row of TABLE_DEPTH cells, one cell per cycle. The first cell
// registers it at the accepting edge; the last cell feeds the result register,
// which raises m_valid. Only one item is in flight at a time: no new item is
// taken until the last result has been taken. Reset is synchronous; it clears
// the allocation and peak counters, sets the id counter to 1 and the limit to
// 16; slot contents need no reset.
// A stalled result holds in the output register and blocks the next item.
module session_table_with_replay_check
    import stab_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [63:0] s_session_id,
    input  logic [63:0] s_epoch_value,
    input  logic [63:0] s_boot_value,
    input  logic [63:0] s_frame_sequence,
    input  logic [63:0] s_nonce_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [63:0] m_rec_id,
    output logic [63:0] m_rec_epoch,
    output logic [63:0] m_rec_boot,
    output logic [63:0] m_rec_nonce,
    output logic [63:0] m_rec_last_sequence,
    output logic [31:0] m_rec_active,
    output logic [4:0]  m_open_count,
    output logic [4:0]  m_peak_slots
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [4:0]    limit_reg;
    logic [CW-1:0] used_reg, used_next;
    logic [4:0]    peak_reg;
    logic [63:0]   idc_reg;
    logic          busy_reg;
    logic          m_valid_reg;
    req_t          res_reg;

    logic [TABLE_DEPTH:0] vchain;
    req_t                 rchain [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] take_vec;
    logic                 accept;
    logic [5:0]           limit_eff;

    assign s_ready = !busy_reg && !m_valid_reg;
    assign accept  = s_valid && s_ready;
    // The limit register is five bits wide, so a table of 32 or more slots is
    // always bounded by the register.
    assign limit_eff = (int'(limit_reg) < TABLE_DEPTH) ? {1'b0, limit_reg}
                                                       : 6'(TABLE_DEPTH);

    // The request enters the row straight from the ports; the first cell registers it.
    assign vchain[0] = accept;
    always_comb begin
        rchain[0]          = '0;
        rchain[0].func     = s_func;
        rchain[0].id       = s_session_id;
        rchain[0].epoch    = s_epoch_value;
        rchain[0].boot     = s_boot_value;
        rchain[0].seq      = s_frame_sequence;
        rchain[0].nonce    = s_nonce_value;
        rchain[0].new_id   = idc_reg;
        rchain[0].alloc    = 6'(used_reg) < limit_eff;
        rchain[0].status   = (s_func == FUNC_CREATE) ? ST_FULL : ST_NOT_FOUND;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            stab_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .in_valid (vchain[g]),
                .in_req   (rchain[g]),
                .used     (used_reg > CW'(g)),
                .take     (take_vec[g]),
                .out_valid(vchain[g+1]),
                .out_req  (rchain[g+1])
            );
        end
    endgenerate

    // Only the first unused slot can take, at most once per item.
    assign used_next = (|take_vec) ? used_reg + CW'(1) : used_reg;

    always_ff @(posedge aclk) begin
        if (vchain[TABLE_DEPTH]) begin
            res_reg <= rchain[TABLE_DEPTH];
        end
        if (!aresetn) begin
            limit_reg   <= 5'd16;
            used_reg    <= '0;
            peak_reg    <= '0;
            idc_reg     <= 64'd1;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_data;
            end
            used_reg <= used_next;
            if (5'(used_next) > peak_reg) begin
                peak_reg <= 5'(used_next);
            end
            if (accept) begin
                busy_reg <= 1'b1;
            end
            // The id counter moves when a create succeeds.
            if (vchain[TABLE_DEPTH] && rchain[TABLE_DEPTH].func == FUNC_CREATE
                && rchain[TABLE_DEPTH].status == ST_OK) begin
                idc_reg <= idc_reg + 64'd1;
            end
            if (vchain[TABLE_DEPTH]) begin
                busy_reg    <= 1'b0;
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = res_reg.status;
    assign m_rec_id            = res_reg.emit ? res_reg.rec.id       : 64'd0;
    assign m_rec_epoch         = res_reg.emit ? res_reg.rec.epoch    : 64'd0;
    assign m_rec_boot          = res_reg.emit ? res_reg.rec.boot     : 64'd0;
    assign m_rec_nonce         = res_reg.emit ? res_reg.rec.nonce    : 64'd0;
    assign m_rec_last_sequence = res_reg.emit ? res_reg.rec.last_seq : 64'd0;
    assign m_rec_active        = res_reg.emit ? res_reg.rec.active   : 32'd0;
    assign m_open_count        = res_reg.open_cnt[4:0];
    assign m_peak_slots        = peak_reg;

endmodule

@@ hdl/stab_cell.sv @@
// One table slot: holds the slot record and acts on the passing request.
// Depends on stab_pkg.
module stab_cell
    import stab_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    input  req_t in_req,
    input  logic used,      // slot already allocated
    output logic take,      // this cell allocates itself
    output logic out_valid,
    output req_t out_req
);

    slot_rec_t rec_reg, rec_next;
    req_t      req_next;
    logic      valid_reg;
    req_t      req_reg;
    logic      hit_open, hit_any;

    always_comb begin
        rec_next = rec_reg;
        req_next = in_req;
        take     = 1'b0;
        hit_open = used && !rec_reg.closed && (rec_reg.id == in_req.id);
        hit_any  = used && (rec_reg.id == in_req.id);
        if (in_valid && !in_req.done) begin
            unique case (in_req.func)
                FUNC_CREATE: begin
                    if ((used && rec_reg.closed) || (!used && in_req.alloc)) begin
                        take           = !used;
                        rec_next       = '{closed: 1'b0, id: in_req.new_id,
                                           epoch: in_req.epoch, boot: in_req.boot,
                                           nonce: in_req.nonce, last_seq: 64'd0,
                                           active: 32'd0};
                        req_next.done  = 1'b1;
                        req_next.emit  = 1'b1;
                        req_next.status = ST_OK;
                        req_next.rec   = rec_next;
                    end
                end
                FUNC_ACCEPT: begin
                    if (hit_open) begin
                        req_next.done = 1'b1;
                        if (rec_reg.epoch != in_req.epoch || rec_reg.boot != in_req.boot
                            || in_req.seq <= rec_reg.last_seq) begin
                            req_next.status = ST_MISMATCH;
                        end else begin
                            req_next.status   = ST_OK;
                            rec_next.last_seq = in_req.seq;
                            if (rec_reg.active != 32'hFFFF_FFFF) begin
                                rec_next.active = rec_reg.active + 32'd1;
                            end
                        end
                    end
                end
                FUNC_RELEASE: begin
                    if (hit_any) begin
                        req_next.done   = 1'b1;
                        req_next.status = ST_OK;
                        rec_next.closed = 1'b1;
                        rec_next.active = 32'd0;
                    end
                end
                FUNC_GET: begin
                    if (hit_open) begin
                        req_next.done   = 1'b1;
                        req_next.status = ST_OK;
                        req_next.emit   = 1'b1;
                        req_next.rec    = rec_reg;
                    end
                end
                default: ;
            endcase
        end
        if ((used || take) && !rec_next.closed) begin
            req_next.open_cnt = in_req.open_cnt + 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            rec_reg <= rec_next;
            req_reg <= req_next;
        end
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid = valid_reg;
    assign out_req   = req_reg;

endmodule

@@ hdl/stab_checker.sv @@
// Port-level checks for the session table, bound to the top level.
// Depends on stab_pkg and session_table_with_replay_check.
module stab_checker
    import stab_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_status,
    input logic [63:0] m_rec_id,
    input logic [4:0] m_open_count,
    input logic [4:0] m_peak_slots
);

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(s_valid && s_ready)) else $error("item accepted while result pending");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)))
        else $error("stalled result changed");

    a_open_le_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_open_count <= m_peak_slots))
        else $error("open count above peak");

    a_fail_no_rec: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_rec_id == 64'd0))
        else $error("record shown on failure");

endmodule

bind session_table_with_replay_check stab_checker u_stab_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_rec_id    (m_rec_id),
    .m_open_count(m_open_count),
    .m_peak_slots(m_peak_slots)
);

@@ bench/session_table_with_replay_check_test.sv @@
// Testbench for the session table with replay check: directed table, then random phases.
// Depends on stab_pkg and session_table_with_replay_check, which in turn needs stab_cell.
`timescale 1ns / 100ps

module session_table_with_replay_check_test
    import stab_pkg::*;
();

    localparam int SLOTS = DEFAULT_TABLE_DEPTH;
    // An item walks SLOTS cells and the result register; the rest is margin.
    localparam int ROW_LATENCY = SLOTS + 8;
    // Longest quiet stretch of a correct run: one item, a full gap, a full stall,
    // and the pause before a register write, with plenty of margin.
    localparam int QUIET_LIMIT = 2000;
    localparam int EXP_DEPTH = 64;

    typedef struct {
        logic [1:0]  func;
        logic [63:0] id;
        logic [63:0] epoch;
        logic [63:0] boot;
        logic [63:0] seq;
        logic [63:0] nonce;
    } request_t;

    typedef struct {
        logic [1:0]  status;
        logic [63:0] id;
        logic [63:0] epoch;
        logic [63:0] boot;
        logic [63:0] nonce;
        logic [63:0] last_seq;
        logic [31:0] active;
        logic [4:0]  open_cnt;
        logic [4:0]  peak;
    } outcome_t;

    // One row of the directed part. Where pinned is set, the status is the one
    // typed in here rather than the one the table mirror works out.
    typedef struct {
        request_t   req;
        logic       pinned;
        logic [1:0] status;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = FUNC_CREATE;
    logic [63:0] s_session_id = '0;
    logic [63:0] s_epoch_value = '0;
    logic [63:0] s_boot_value = '0;
    logic [63:0] s_frame_sequence = '0;
    logic [63:0] s_nonce_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic [1:0]  m_status;
    logic [63:0] m_rec_id;
    logic [63:0] m_rec_epoch;
    logic [63:0] m_rec_boot;
    logic [63:0] m_rec_nonce;
    logic [63:0] m_rec_last_sequence;
    logic [31:0] m_rec_active;
    logic [4:0]  m_open_count;
    logic [4:0]  m_peak_slots;

    session_table_with_replay_check i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_we              (cfg_we),
        .cfg_data            (cfg_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_func              (s_func),
        .s_session_id        (s_session_id),
        .s_epoch_value       (s_epoch_value),
        .s_boot_value        (s_boot_value),
        .s_frame_sequence    (s_frame_sequence),
        .s_nonce_value       (s_nonce_value),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_rec_id            (m_rec_id),
        .m_rec_epoch         (m_rec_epoch),
        .m_rec_boot          (m_rec_boot),
        .m_rec_nonce         (m_rec_nonce),
        .m_rec_last_sequence (m_rec_last_sequence),
        .m_rec_active        (m_rec_active),
        .m_open_count        (m_open_count),
        .m_peak_slots        (m_peak_slots)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Mirror of the session table. Slots are allocated in order and never
    // given back; a closed slot is only ever reused by a later create.
    logic        tbl_closed [SLOTS];
    logic [63:0] tbl_id     [SLOTS];
    logic [63:0] tbl_epoch  [SLOTS];
    logic [63:0] tbl_boot   [SLOTS];
    logic [63:0] tbl_nonce  [SLOTS];
    logic [63:0] tbl_seq    [SLOTS];
    logic [31:0] tbl_count  [SLOTS];
    int          tbl_used = 0;
    int          tbl_peak = 0;
    logic [63:0] next_session_id = 64'd1;
    logic [4:0]  limit_reg = 5'd16;

    // Expected results in order of acceptance, kept in a ring.
    outcome_t    exp_ring [EXP_DEPTH];
    int          exp_head = 0;
    int          exp_tail = 0;
    int          exp_count = 0;
    int          error_count = 0;
    int          quiet_cycles = 0;
    bit          idling_on = 1'b1;

    // Lowest allocated slot holding the id, optionally skipping closed ones.
    function automatic int find_session(logic [63:0] id, bit open_only);
        for (int i = 0; i < tbl_used; i++) begin
            if (tbl_id[i] == id && !(open_only && tbl_closed[i])) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Apply one request to the mirror and return the result it must produce.
    function automatic outcome_t apply_request(request_t r);
        outcome_t o;
        int       s;
        int       eff_limit;
        int       open_n;
        o = '{status: ST_OK, default: '0};
        s = -1;
        case (r.func)
            FUNC_CREATE: begin
                eff_limit = (limit_reg < SLOTS) ? int'(limit_reg) : SLOTS;
                for (int i = 0; i < tbl_used; i++) begin
                    if (s < 0 && tbl_closed[i]) begin
                        s = i;
                    end
                end
                if (s < 0) begin
                    if (tbl_used >= eff_limit) begin
                        o.status = ST_FULL;
                    end else begin
                        s = tbl_used;
                        tbl_used++;
                        if (tbl_used > tbl_peak) begin
                            tbl_peak = tbl_used;
                        end
                    end
                end
                if (s >= 0) begin
                    tbl_id[s]     = next_session_id;
                    next_session_id++;
                    tbl_epoch[s]  = r.epoch;
                    tbl_boot[s]   = r.boot;
                    tbl_nonce[s]  = r.nonce;
                    tbl_seq[s]    = '0;
                    tbl_count[s]  = '0;
                    tbl_closed[s] = 1'b0;
                end
            end
            FUNC_ACCEPT: begin
                s = find_session(r.id, 1'b1);
                if (s < 0) begin
                    o.status = ST_NOT_FOUND;
                end else if (tbl_epoch[s] != r.epoch || tbl_boot[s] != r.boot
                             || r.seq <= tbl_seq[s]) begin
                    o.status = ST_MISMATCH;
                end else begin
                    tbl_seq[s] = r.seq;
                    if (tbl_count[s] != 32'hFFFF_FFFF) begin
                        tbl_count[s]++;
                    end
                end
                s = -1;
            end
            FUNC_RELEASE: begin
                s = find_session(r.id, 1'b0);
                if (s < 0) begin
                    o.status = ST_NOT_FOUND;
                end else begin
                    tbl_closed[s] = 1'b1;
                    tbl_count[s]  = '0;
                end
                s = -1;
            end
            default: begin
                s = find_session(r.id, 1'b1);
                if (s < 0) begin
                    o.status = ST_NOT_FOUND;
                end
            end
        endcase
        // Only a successful create or get reports the record.
        if (s >= 0) begin
            o.id       = tbl_id[s];
            o.epoch    = tbl_epoch[s];
            o.boot     = tbl_boot[s];
            o.nonce    = tbl_nonce[s];
            o.last_seq = tbl_seq[s];
            o.active   = tbl_count[s];
        end
        open_n = 0;
        for (int i = 0; i < tbl_used; i++) begin
            if (!tbl_closed[i]) begin
                open_n++;
            end
        end
        o.open_cnt = 5'(open_n);
        o.peak     = 5'(tbl_peak);
        return o;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random request. Most are well formed against a live session so that the
    // sequence check and record updates are reached; the rest are noise.
    function automatic request_t random_request();
        request_t r;
        int       pick;
        int       k;
        r.func  = 2'($urandom_range(0, 3));
        r.id    = rand64();
        r.epoch = rand64();
        r.boot  = rand64();
        r.seq   = rand64();
        r.nonce = rand64();
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            r.func = FUNC_CREATE;
        end else if (pick < 60) begin
            r.func = FUNC_ACCEPT;
        end else if (pick < 72) begin
            r.func = FUNC_RELEASE;
        end else if (pick < 90) begin
            r.func = FUNC_GET;
        end
        // Noise (the last tenth) keeps fully random fields.
        if (pick < 90 && tbl_used > 0 && r.func != FUNC_CREATE) begin
            k = $urandom_range(0, tbl_used - 1);
            r.id = tbl_id[k];
            if ($urandom_range(0, 99) < 85) begin
                r.epoch = tbl_epoch[k];
                r.boot  = tbl_boot[k];
            end else if ($urandom_range(0, 1) == 1) begin
                r.epoch = tbl_epoch[k];
            end else begin
                r.boot = tbl_boot[k];
            end
            case ($urandom_range(0, 9))
                0:       r.seq = tbl_seq[k];
                1:       r.seq = tbl_seq[k] - 64'($urandom_range(1, 50));
                2:       r.seq = rand64();
                default: r.seq = tbl_seq[k] + 64'($urandom_range(1, 1000));
            endcase
        end
        return r;
    endfunction

    // Present one request and hold it until taken. The expectation is recorded
    // at the edge of acceptance, so the mirror sees requests in block order.
    task automatic send_request(request_t r, bit pinned, logic [1:0] pin_status);
        outcome_t o;
        s_valid          <= 1'b1;
        s_func           <= r.func;
        s_session_id     <= r.id;
        s_epoch_value    <= r.epoch;
        s_boot_value     <= r.boot;
        s_frame_sequence <= r.seq;
        s_nonce_value    <= r.nonce;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        quiet_cycles = 0;
        o = apply_request(r);
        if (pinned) begin
            o.status = pin_status;
        end
        exp_ring[exp_tail] = o;
        exp_tail = (exp_tail + 1) % EXP_DEPTH;
        exp_count++;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    // Stop sending and wait until every outstanding result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (exp_count != 0) begin
            @(posedge aclk);
        end
    endtask

    // Register write while the block is idle.
    task automatic write_limit(logic [4:0] value);
        drain_results();
        repeat (ROW_LATENCY) @(posedge aclk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        limit_reg  = value;
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // Result side: compare each taken result with the oldest expectation and
    // stall in random bursts while idling is on.
    initial begin : result_monitor
        outcome_t o;
        int       stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                quiet_cycles = 0;
                if (exp_count == 0) begin
                    error_count++;
                    $display("%0t ns: result with no request outstanding, status %0d",
                             $time, m_status);
                end else begin
                    o = exp_ring[exp_head];
                    exp_head = (exp_head + 1) % EXP_DEPTH;
                    exp_count--;
                    check_field("status", o.status, m_status);
                    check_field("rec_id", o.id, m_rec_id);
                    check_field("rec_epoch", o.epoch, m_rec_epoch);
                    check_field("rec_boot", o.boot, m_rec_boot);
                    check_field("rec_nonce", o.nonce, m_rec_nonce);
                    check_field("rec_last_sequence", o.last_seq, m_rec_last_sequence);
                    check_field("rec_active", o.active, m_rec_active);
                    check_field("open_count", o.open_cnt, m_open_count);
                    check_field("peak_slots", o.peak, m_peak_slots);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any item or result moving ends the run.
    initial begin : watchdog
        forever begin
            @(posedge aclk);
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("session_table_with_replay_check_test NOT OK");
                $finish;
            end
        end
    end

    localparam logic [63:0] ALL_ONES = '1;

    // Directed part, run at a limit of one slot. Session 1 is created with
    // epoch all ones and boot zero; session 2 later reuses its slot.
    stim_row_t directed_rows [] = '{
        '{'{FUNC_CREATE, 64'd0, ALL_ONES, 64'd0, 64'd0, ALL_ONES}, 1'b1, ST_OK},
        '{'{FUNC_CREATE, 64'd0, 64'd5, 64'd6, 64'd0, 64'd7}, 1'b1, ST_FULL},
        '{'{FUNC_GET, 64'd1, 64'd0, 64'd0, 64'd0, 64'd0}, 1'b1, ST_OK},
        '{'{FUNC_ACCEPT, 64'd1, ALL_ONES, 64'd0, 64'd0, 64'd0}, 1'b1, ST_MISMATCH},
        '{'{FUNC_ACCEPT, 64'd1, ALL_ONES, 64'd0, 64'd1, 64'd0}, 1'b1, ST_OK},
        '{'{FUNC_ACCEPT, 64'd1, ALL_ONES, 64'd0, 64'd1, 64'd0}, 1'b1, ST_MISMATCH},
        '{'{FUNC_ACCEPT, 64'd1, 64'd0, 64'd0, 64'd5, 64'd0}, 1'b1, ST_MISMATCH},
        '{'{FUNC_ACCEPT, 64'd1, ALL_ONES, ALL_ONES, 64'd5, 64'd0}, 1'b1, ST_MISMATCH},
        '{'{FUNC_ACCEPT, 64'd1, ALL_ONES, 64'd0, ALL_ONES, 64'd0}, 1'b1, ST_OK},
        '{'{FUNC_ACCEPT, 64'd1, ALL_ONES, 64'd0, ALL_ONES, 64'd0}, 1'b1, ST_MISMATCH},
        '{'{FUNC_GET, 64'd1, 64'd0, 64'd0, 64'd0, 64'd0}, 1'b0, ST_OK},
        '{'{FUNC_GET, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0}, 1'b1, ST_NOT_FOUND},
        '{'{FUNC_GET, ALL_ONES, 64'd0, 64'd0, 64'd0, 64'd0}, 1'b1, ST_NOT_FOUND},
        '{'{FUNC_RELEASE, 64'd1, 64'd0, 64'd0, 64'd0, 64'd0}, 1'b1, ST_OK},
        '{'{FUNC_RELEASE, 64'd1, 64'd0, 64'd0, 64'd0, 64'd0}, 1'b1, ST_OK},
        '{'{FUNC_ACCEPT, 64'd1, ALL_ONES, 64'd0, 64'd9, 64'd0}, 1'b1, ST_NOT_FOUND},
        '{'{FUNC_GET, 64'd1, 64'd0, 64'd0, 64'd0, 64'd0}, 1'b1, ST_NOT_FOUND},
        '{'{FUNC_CREATE, 64'd0, 64'd0, ALL_ONES, 64'd0, 64'd0}, 1'b1, ST_OK},
        '{'{FUNC_GET, 64'd2, 64'd0, 64'd0, 64'd0, 64'd0}, 1'b0, ST_OK},
        '{'{FUNC_RELEASE, 64'd7, 64'd0, 64'd0, 64'd0, 64'd0}, 1'b1, ST_NOT_FOUND}
    };

    // Limits of the random phases: zero (only closed slots reused), a small
    // table, a value beyond the table, the full table, and a single slot.
    logic [4:0] phase_limits [] = '{5'd0, 5'd3, 5'd31, 5'd16, 5'd1};

    initial begin : stimulus
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_limit(5'd1);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].pinned,
                         directed_rows[i].status);
        end

        foreach (phase_limits[p]) begin
            write_limit(phase_limits[p]);
            // The last phase runs with both sides at full rate.
            idling_on = (p != phase_limits.size() - 1);
            for (int n = 0; n < 360; n++) begin
                if (p == 1 && n == 180) begin
                    drain_results();
                end
                send_request(random_request(), 1'b0, ST_OK);
            end
        end

        drain_results();
        repeat (ROW_LATENCY) @(posedge aclk);
        if (error_count == 0 && exp_count == 0) begin
            $display("session_table_with_replay_check_test OK");
        end else begin
            $display("session_table_with_replay_check_test NOT OK");
        end
        $finish;
    end

endmodule
